// File: design/sed_pkg.sv
package sed_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_START_BYTE = 2'd0;
    localparam logic [1:0] REG_END_BYTE   = 2'd1;
    localparam logic [1:0] REG_MAX_LEN    = 2'd2;

    // Reset values of the configuration registers
    localparam logic [7:0]  START_BYTE_RST = 8'h02;
    localparam logic [7:0]  END_BYTE_RST   = 8'h03;
    localparam logic [10:0] MAX_LEN_RST    = 11'd1024;

    // Smallest frame length the limit may take
    localparam logic [10:0] LEN_FLOOR = 11'd4;

    // CRC-16/Modbus
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Frame status codes
    localparam logic [1:0] STAT_CRC_OK   = 2'd0;
    localparam logic [1:0] STAT_CRC_BAD  = 2'd1;
    localparam logic [1:0] STAT_OVERFLOW = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_BODY   = 2'd1,
        PH_CRC_HI = 2'd2,
        PH_CRC_LO = 2'd3
    } phase_t;

    // Settings seen by the deframer
    typedef struct packed {
        logic [7:0]  start_byte;
        logic [7:0]  end_byte;
        logic [10:0] limit;
    } cfg_t;

    // One result item
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        in_frame;
        logic [9:0]  byte_position;
        logic        frame_end;
        logic [1:0]  frame_status;
        logic [10:0] frame_length;
    } result_t;

    // Bytewise reflected CRC update
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// File: design/stx_etx_crc16_deframer.sv
// Channel   Handshake              Payload
// -------   ---------------------  ----------------------------------------------
// input     in_valid / in_ready    rx_byte
// output    out_valid / out_ready  out_byte, in_frame, byte_position, frame_end,
//                                  frame_status, frame_length
// config    APB, pready always 1   start_byte @0x0, end_byte @0x4, max length @0x8
//
// One byte per cycle unless the output stalls; bytes pass the input register, the
// CRC/state step and the result register. The bytewise CRC network sets the path.
// Reset clears the frame state to idle and loads the register defaults.
// A stalled output holds its result; one more byte waits in the input register.
module stx_etx_crc16_deframer #(
    parameter int MAX_FRAME_BYTES = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        in_frame,
    output logic [9:0]  byte_position,
    output logic        frame_end,
    output logic [1:0]  frame_status,
    output logic [10:0] frame_length,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sed_pkg::*;

    localparam int LEN_TOP_INT = (MAX_FRAME_BYTES > 1024) ? 1024 : MAX_FRAME_BYTES;
    localparam logic [10:0] LEN_TOP = LEN_TOP_INT[10:0];

    cfg_t    cfg;
    result_t result;

    sed_cfg #(
        .LEN_TOP (LEN_TOP)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sed_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    // Break the result out onto its ports
    assign out_byte      = result.out_byte;
    assign in_frame      = result.in_frame;
    assign byte_position = result.byte_position;
    assign frame_end     = result.frame_end;
    assign frame_status  = result.frame_status;
    assign frame_length  = result.frame_length;

endmodule

// File: design/sed_cfg.sv
module sed_cfg #(
    parameter logic [10:0] LEN_TOP = 11'd1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output sed_pkg::cfg_t       cfg
);
    import sed_pkg::*;

    logic [7:0]  start_byte_reg;
    logic [7:0]  end_byte_reg;
    logic [10:0] max_len_reg;
    logic [1:0]  reg_index;
    logic        wr_en;
    logic [10:0] lim_hi;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign wr_en     = psel & penable & pwrite;

    // Write registers on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= START_BYTE_RST;
            end_byte_reg   <= END_BYTE_RST;
            max_len_reg    <= MAX_LEN_RST;
        end
        else if (wr_en)
        begin
            case (reg_index)
                REG_START_BYTE: start_byte_reg <= pwdata[7:0];
                REG_END_BYTE:   end_byte_reg   <= pwdata[7:0];
                REG_MAX_LEN:    max_len_reg    <= pwdata[10:0];
                default:        ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (reg_index)
            REG_START_BYTE: prdata = {24'd0, start_byte_reg};
            REG_END_BYTE:   prdata = {24'd0, end_byte_reg};
            REG_MAX_LEN:    prdata = {21'd0, max_len_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // Clamp the length limit
    always_comb
    begin
        lim_hi = (max_len_reg > LEN_TOP) ? LEN_TOP : max_len_reg;
        cfg.start_byte = start_byte_reg;
        cfg.end_byte   = end_byte_reg;
        cfg.limit      = (lim_hi < LEN_FLOOR) ? LEN_FLOOR : lim_hi;
    end

endmodule

// File: design/sed_core.sv
module sed_core (
    input  logic                clk,
    input  logic                rst_n,
    input  sed_pkg::cfg_t       cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          rx_byte,
    output logic                out_valid,
    input  logic                out_ready,
    output sed_pkg::result_t    result
);
    import sed_pkg::*;

    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    phase_t      phase_reg, phase_next;
    logic [15:0] crc_reg, crc_next;
    logic [10:0] count_reg, count_next;
    logic [15:0] exp_reg, exp_next;
    logic        out_valid_reg;
    result_t     out_reg, out_next;
    logic        advance;
    logic [7:0]  b;
    logic [10:0] count_inc;

    assign advance   = s1_valid_reg & (~out_valid_reg | out_ready);
    assign in_ready  = ~s1_valid_reg | advance;
    assign out_valid = out_valid_reg;
    assign result    = out_reg;
    assign b         = s1_byte_reg;
    assign count_inc = count_reg + 11'd1;

    // Hold input request until the step logic takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_valid && in_ready)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_byte_reg <= rx_byte;
    end

    // Frame state and result for one byte
    always_comb
    begin
        phase_next = phase_reg;
        crc_next   = crc_reg;
        count_next = count_reg;
        exp_next   = exp_reg;
        out_next   = '0;
        out_next.out_byte = b;
        case (phase_reg)
            PH_IDLE:
            begin
                if (b == cfg.start_byte)
                begin
                    crc_next   = crc_byte(CRC_INIT, b);
                    count_next = 11'd1;
                    phase_next = PH_BODY;
                    out_next.in_frame = 1'b1;
                end
            end
            default:
            begin
                out_next.in_frame      = 1'b1;
                out_next.byte_position = count_reg[9:0];
                if (count_inc > cfg.limit)
                begin
                    // Drop an oversized frame
                    out_next.frame_end    = 1'b1;
                    out_next.frame_status = STAT_OVERFLOW;
                    out_next.frame_length = count_reg;
                    phase_next = PH_IDLE;
                    crc_next   = CRC_INIT;
                    count_next = 11'd0;
                    exp_next   = 16'd0;
                end
                else if (phase_reg == PH_BODY)
                begin
                    crc_next   = crc_byte(crc_reg, b);
                    count_next = count_inc;
                    if (b == cfg.end_byte)
                        phase_next = PH_CRC_HI;
                end
                else if (phase_reg == PH_CRC_HI)
                begin
                    exp_next   = crc_reg ^ {b, 8'h00};
                    count_next = count_inc;
                    phase_next = PH_CRC_LO;
                end
                else
                begin
                    out_next.frame_end    = 1'b1;
                    out_next.frame_status = (exp_reg == {8'h00, b}) ? STAT_CRC_OK
                                                                    : STAT_CRC_BAD;
                    out_next.frame_length = count_inc;
                    phase_next = PH_IDLE;
                    crc_next   = CRC_INIT;
                    count_next = 11'd0;
                    exp_next   = 16'd0;
                end
            end
        endcase
    end

    // Advance frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            crc_reg   <= CRC_INIT;
            count_reg <= 11'd0;
            exp_reg   <= 16'd0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            crc_reg   <= crc_next;
            count_reg <= count_next;
            exp_reg   <= exp_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= out_next;
    end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import sed_pkg::*;

    localparam int FRAME_CAP   = 1024;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte;
    logic        in_frame;
    logic [9:0]  byte_position;
    logic        frame_end;
    logic [1:0]  frame_status;
    logic [10:0] frame_length;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'h0;
    logic [31:0] pwdata = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    stx_etx_crc16_deframer #(
        .MAX_FRAME_BYTES(FRAME_CAP)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_byte(out_byte),
        .in_frame(in_frame),
        .byte_position(byte_position),
        .frame_end(frame_end),
        .frame_status(frame_status),
        .frame_length(frame_length),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #5 clk = ~clk;

    // Deframer state and register copies
    logic [7:0]  cfg_start = START_BYTE_RST;
    logic [7:0]  cfg_end = END_BYTE_RST;
    logic [10:0] cfg_max_len = MAX_LEN_RST;
    phase_t      ph = PH_IDLE;
    logic [15:0] crc_acc = CRC_INIT;
    logic [10:0] count = 11'd0;
    logic [15:0] chk_crc = 16'h0;

    // Bytes waiting to be sent and results still due
    logic [7:0]  tx_bytes[$];
    logic [7:0]  frame_body[$];
    result_t     due_results[$];
    result_t     head;

    int idle_pct = 0;
    int stall_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int queued_total = 0;
    int n_results = 0;
    int n_ok = 0;
    int n_bad = 0;
    int n_ovf = 0;
    int mismatches = 0;
    int cycle_count = 0;

    // Reflected CRC-16 update, one bit at a time, LSB first
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ b[i];
            c = c >> 1;
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    function automatic int frame_limit(input logic [10:0] m);
        int lim;
        lim = m;
        if (lim > FRAME_CAP)
            lim = FRAME_CAP;
        if (lim < LEN_FLOOR)
            lim = LEN_FLOOR;
        return lim;
    endfunction

    task automatic clear_frame();
        ph = PH_IDLE;
        crc_acc = CRC_INIT;
        count = 11'd0;
        chk_crc = 16'h0;
    endtask

    // Advance the deframer by one byte and build the result it reports
    task automatic deframe_byte(input logic [7:0] b, output result_t r);
        int lim;
        lim = frame_limit(cfg_max_len);
        r = '0;
        r.out_byte = b;
        if (ph == PH_IDLE)
        begin
            if (b == cfg_start)
            begin
                crc_acc = crc16_step(CRC_INIT, b);
                count = 11'd1;
                ph = PH_BODY;
                r.in_frame = 1'b1;
            end
        end
        else
        begin
            r.in_frame = 1'b1;
            r.byte_position = count[9:0];
            if (count + 1 > lim)
            begin
                r.frame_end = 1'b1;
                r.frame_status = STAT_OVERFLOW;
                r.frame_length = count;
                clear_frame();
            end
            else
            begin
                case (ph)
                    PH_BODY:
                    begin
                        crc_acc = crc16_step(crc_acc, b);
                        count = count + 11'd1;
                        if (b == cfg_end)
                            ph = PH_CRC_HI;
                    end
                    PH_CRC_HI:
                    begin
                        chk_crc = crc_acc ^ {b, 8'h00};
                        count = count + 11'd1;
                        ph = PH_CRC_LO;
                    end
                    default:
                    begin
                        count = count + 11'd1;
                        r.frame_end = 1'b1;
                        r.frame_status = (chk_crc == {8'h00, b}) ? STAT_CRC_OK : STAT_CRC_BAD;
                        r.frame_length = count;
                        clear_frame();
                    end
                endcase
            end
        end
    endtask

    // Input driver: track each accepted request, then offer the next byte
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                deframe_byte(rx_byte, head);
                due_results.push_back(head);
            end
            if (!in_valid || in_ready)
            begin
                if (tx_bytes.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    in_valid <= 1'b1;
                    rx_byte <= tx_bytes.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output ready: long hold-off on request, random stalls otherwise
    always @(posedge clk)
    begin
        if (hold_seen != hold_req)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // Output monitor: compare each result with the oldest one due
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            n_results++;
            if (due_results.size() == 0)
            begin
                $error("result with none due: out_byte %0h", out_byte);
                mismatches++;
            end
            else
            begin
                head = due_results.pop_front();
                check_field("out_byte", head.out_byte, out_byte);
                check_field("in_frame", head.in_frame, in_frame);
                check_field("byte_position", head.byte_position, byte_position);
                check_field("frame_end", head.frame_end, frame_end);
                check_field("frame_status", head.frame_status, frame_status);
                check_field("frame_length", head.frame_length, frame_length);
                if (head.frame_end)
                begin
                    case (head.frame_status)
                        STAT_CRC_OK:  n_ok++;
                        STAT_CRC_BAD: n_bad++;
                        default:      n_ovf++;
                    endcase
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    task automatic queue_byte(input logic [7:0] b);
        tx_bytes.push_back(b);
        queued_total++;
    endtask

    // Queue start, body, end and CRC (high byte first), optionally corrupted
    task automatic send_frame(input logic [15:0] crc_flip);
        logic [15:0] c;
        c = crc16_step(CRC_INIT, cfg_start);
        queue_byte(cfg_start);
        foreach (frame_body[i])
        begin
            c = crc16_step(c, frame_body[i]);
            queue_byte(frame_body[i]);
        end
        c = crc16_step(c, cfg_end);
        queue_byte(cfg_end);
        c = c ^ crc_flip;
        queue_byte(c[15:8]);
        queue_byte(c[7:0]);
    endtask

    task automatic fill_body(input int n);
        logic [7:0] b;
        frame_body.delete();
        for (int i = 0; i < n; i++)
        begin
            b = 8'($urandom_range(0, 255));
            while (b == cfg_end)
                b = 8'($urandom_range(0, 255));
            frame_body.push_back(b);
        end
    endtask

    // Hold until every request is sent and every result is in
    task automatic settle();
        while (tx_bytes.size() != 0 || in_valid || due_results.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (addr[3:2])
            REG_START_BYTE: cfg_start = data[7:0];
            REG_END_BYTE:   cfg_end = data[7:0];
            REG_MAX_LEN:    cfg_max_len = data[10:0];
            default:        ;
        endcase
    endtask

    // Reprogram while idle, then queue a mix of frames, damage and noise
    task automatic run_phase(input logic [7:0] s, input logic [7:0] e, input logic [10:0] m,
                             input int n_bytes, input int idle, input int stall,
                             input int body_cap);
        int lim;
        int stop_at;
        int kind;
        int top;
        settle();
        apb_write({REG_START_BYTE, 2'b00}, {24'h0, s});
        apb_write({REG_END_BYTE, 2'b00}, {24'h0, e});
        apb_write({REG_MAX_LEN, 2'b00}, {21'h0, m});
        idle_pct = idle;
        stall_pct = stall;
        lim = frame_limit(cfg_max_len);
        top = (lim - 4 < body_cap) ? lim - 4 : body_cap;
        stop_at = queued_total + n_bytes;
        while (queued_total < stop_at)
        begin
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range(0, 255)));
            kind = $urandom_range(0, 99);
            if (kind < 10 && lim - 1 <= body_cap)
            begin
                fill_body(lim - 3 + $urandom_range(0, 2));
                send_frame(16'h0);
            end
            else if (kind < 20)
            begin
                fill_body($urandom_range(0, top));
                if ($urandom_range(0, 1) == 0)
                    send_frame(16'h1 << $urandom_range(0, 15));
                else
                    send_frame(16'($urandom_range(1, 16'hFFFF)));
            end
            else if (kind < 26)
            begin
                queue_byte(cfg_start);
                repeat ($urandom_range(0, 3)) queue_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                fill_body($urandom_range(0, top));
                send_frame(16'h0);
            end
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: idle noise, extreme body bytes, bad CRC high and low
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(END_BYTE_RST);
        frame_body = {8'h00, 8'hFF, 8'h55, 8'hAA};
        send_frame(16'h0);
        frame_body.delete();
        send_frame(16'hFF00);
        frame_body = {8'h80};
        send_frame(16'h0001);
        frame_body = {START_BYTE_RST};
        send_frame(16'h0);

        // Start equal to end, limit clamped up to the floor, unmapped address
        settle();
        apb_write(4'hC, $urandom);
        run_phase(8'h7E, 8'h7E, 11'd0, 100, 0, 0, 64);

        run_phase(8'h00, 8'hFF, 11'd12, 120, 70, 0, 64);
        run_phase(8'hFF, 8'h00, 11'd40, 120, 0, 70, 64);

        // Limit clamped down to the cap; one full-length frame
        run_phase(8'h55, 8'hAA, 11'h7FF, 110, 34, 34, 30);
        fill_body(FRAME_CAP - 4);
        send_frame(16'h0);

        // Back to defaults; receiver holds off while the sender keeps going
        run_phase(START_BYTE_RST, END_BYTE_RST, MAX_LEN_RST, 140, 0, 0, 40);
        hold_req++;

        run_phase(8'h10, 8'h20, 11'd5, 110, 34, 34, 64);

        settle();
        repeat (10) @(posedge clk);
        $display("covered %0d bytes, %0d results checked", queued_total, n_results);
        $display("frames closed: %0d crc ok, %0d crc bad, %0d overflow", n_ok, n_bad, n_ovf);
        if (mismatches == 0 && due_results.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// File: filelist.f
design/sed_pkg.sv
design/sed_cfg.sv
design/sed_core.sv
design/stx_etx_crc16_deframer.sv
verif/testbench.sv
